// ===== rtl/skh_pkg.sv =====
// Shared types and constants for the streaming key hasher.
package skh_pkg;

   localparam int INDEX_BITS_DEFAULT = 10;
   localparam int COUNT_BITS         = 12;
   localparam int LANES              = 8;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 12'hfff;

   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_SP = 8'h20;

   // Lane code meaning "no delimiter in this word".
   localparam logic [3:0] LANE_NONE = 4'd8;
   // Last lane; nothing can follow a delimiter here.
   localparam logic [3:0] LANE_LAST = 4'd7;

   typedef struct packed {
      logic        delim_found;
      logic [3:0]  lane;        // delimiter lane, LANE_NONE if absent
      logic [63:0] piece;       // key bytes, right-justified
      logic [63:0] rest;        // bytes after delimiter (and LF), left-aligned
      logic [2:0]  rest_bytes;
   } scan_type;

endpackage

// ===== rtl/skh_scan.sv =====
// Delimiter search over eight byte lanes, key piece and rest extraction.
module skh_scan (
   input  logic [63:0]      word,
   output skh_pkg::scan_type scan
);

   logic [3:0]  lane;
   logic [7:0]  lane_byte;
   logic [6:0]  piece_shift;
   logic [6:0]  rest_shift;
   logic [63:0] rest_pre;
   logic [2:0]  rest_n;

   // First delimiter from the top lane (lane 0, bits 63:56) wins.
   always_comb begin
      lane      = skh_pkg::LANE_NONE;
      lane_byte = '0;
      for (int i = skh_pkg::LANES - 1; i >= 0; i--) begin
         lane_byte = word[63 - 8*i -: 8];
         if (lane_byte == skh_pkg::CH_CR || lane_byte == skh_pkg::CH_SP) begin
            lane = 4'(i);
         end
      end
   end

   assign piece_shift = 7'd64 - {lane, 3'b000};
   assign rest_shift  = {lane + 4'd1, 3'b000};

   always_comb begin
      scan.delim_found = (lane != skh_pkg::LANE_NONE);
      scan.lane        = lane;
      if (lane == 4'd0) begin
         scan.piece = '0;
      end else begin
         scan.piece = word >> piece_shift;
      end

      if (lane == skh_pkg::LANE_NONE || lane == skh_pkg::LANE_LAST) begin
         rest_pre = '0;
         rest_n   = '0;
      end else begin
         rest_pre = word << rest_shift;
         rest_n   = 3'(skh_pkg::LANE_LAST - lane);
      end

      // One LF right after the delimiter is dropped.
      if (rest_n != 3'd0 && rest_pre[63:56] == skh_pkg::CH_LF) begin
         scan.rest       = rest_pre << 8;
         scan.rest_bytes = rest_n - 3'd1;
      end else begin
         scan.rest       = rest_pre;
         scan.rest_bytes = rest_n;
      end
   end

endmodule

// ===== rtl/skh_wang.sv =====
// 64-bit shift-add integer hash, combinational.
module skh_wang (
   input  logic [63:0] key,
   output logic [63:0] hash
);

   logic [63:0] k1, k2, k3, k4, k5, k6;

   assign k1   = (~key) + (key << 21);
   assign k2   = k1 ^ (k1 >> 24);
   assign k3   = (k2 + (k2 << 3)) + (k2 << 8);
   assign k4   = k3 ^ (k3 >> 14);
   assign k5   = (k4 + (k4 << 2)) + (k4 << 4);
   assign k6   = k5 ^ (k5 >> 28);
   assign hash = k6 + (k6 << 31);

endmodule

// ===== rtl/streaming_key_hasher.sv =====
// Top level: streaming key hasher, one text word in, one result item out.
// Path: req accept loads the input register, then the result register drives rsp_valid.
// Throughput: one item per cycle while rsp_ready holds; the scan and hash sit between the two
//   registers, and the running count/index update in the same cycle the result is loaded.
// Reset (synchronous, active high) clears both valid flags, the byte count and
//   the hash index; payload registers are not reset.
module streaming_key_hasher #(
   parameter int INDEX_BITS = skh_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [63:0]           req_text_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_key_done,
   output logic [63:0]           rsp_key_piece,
   output logic [3:0]            rsp_piece_bytes,
   output logic [INDEX_BITS-1:0] rsp_bucket_index,
   output logic [11:0]           rsp_key_length,
   output logic [63:0]           rsp_rest_word,
   output logic [2:0]            rsp_rest_bytes
);

   localparam int CB = skh_pkg::COUNT_BITS;
   // Width for hash + count sum before it is folded into the index.
   localparam int SW = (INDEX_BITS > CB) ? INDEX_BITS : CB;

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [63:0] in_word_ff;

   // Running key state
   logic [CB-1:0]         count_ff, count_in;
   logic [INDEX_BITS-1:0] acc_ff, acc_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  key_done_ff;
   logic [63:0]           piece_ff;
   logic [3:0]            piece_bytes_ff;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic [CB-1:0]         length_ff;
   logic [63:0]           rest_ff;
   logic [2:0]            rest_bytes_ff;

   // Datapath
   skh_pkg::scan_type     scan;
   logic [63:0]           hash;
   logic [3:0]            add_bytes;
   logic [CB:0]           count_sum;
   logic [CB-1:0]         count_sat;
   logic [CB-1:0]         hash_count;
   logic [SW-1:0]         mix_sum;
   logic [INDEX_BITS-1:0] mix;

   logic accept, advance, out_free;

   // Handshake: the input register drains whenever the result register is
   // empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   skh_scan u_scan (
      .word (in_word_ff),
      .scan (scan)
   );

   // Whole word when no delimiter; key tail otherwise (piece == word then).
   skh_wang u_wang (
      .key  (scan.piece),
      .hash (hash)
   );

   // Count grows by 8 for a whole key word, by the lane for the closing word.
   assign add_bytes = scan.delim_found ? scan.lane : 4'd8;
   assign count_sum = {1'b0, count_ff} + (CB+1)'(add_bytes);
   assign count_sat = count_sum[CB] ? skh_pkg::COUNT_MAX : count_sum[CB-1:0];

   // Whole words mix in the updated count, the closing word the old one.
   assign hash_count = scan.delim_found ? count_ff : count_sat;
   assign mix_sum    = hash[SW-1:0] + SW'(hash_count);
   assign mix        = mix_sum[INDEX_BITS-1:0];

   always_comb begin
      // A delimiter in the first lane leaves the index untouched.
      if (scan.lane == 4'd0) begin
         index_in = acc_ff;
      end else begin
         index_in = acc_ff ^ mix;
      end

      if (scan.delim_found) begin
         count_in = '0;
         acc_in   = '0;
      end else begin
         count_in = count_sat;
         acc_in   = index_in;
      end

      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            count_ff <= count_in;
            acc_ff   <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_text_word;
      end
      if (advance) begin
         key_done_ff    <= scan.delim_found;
         piece_ff       <= scan.piece;
         piece_bytes_ff <= add_bytes;
         index_ff       <= index_in;
         length_ff      <= count_sat;
         rest_ff        <= scan.rest;
         rest_bytes_ff  <= scan.rest_bytes;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_done     = key_done_ff;
   assign rsp_key_piece    = piece_ff;
   assign rsp_piece_bytes  = piece_bytes_ff;
   assign rsp_bucket_index = index_ff;
   assign rsp_key_length   = length_ff;
   assign rsp_rest_word    = rest_ff;
   assign rsp_rest_bytes   = rest_bytes_ff;

   // A closing word clears the running key state.
   a_state_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && scan.delim_found) |=> (count_ff == '0 && acc_ff == '0))
      else $error("key state not cleared after delimiter");

   // A word held in the input register stays put while the output is blocked.
   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("input register lost a stalled item");

   // A whole key word carries eight bytes, no rest, and at least eight counted.
   a_whole_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_key_done) |->
         (rsp_piece_bytes == 4'd8 && rsp_rest_bytes == 3'd0 && rsp_key_length >= 12'd8))
      else $error("whole key word result inconsistent");

   // A closing word never reports more key bytes than lanes before the last.
   a_closing_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_done) |->
         (rsp_piece_bytes <= 4'd7 && 4'(rsp_rest_bytes) + rsp_piece_bytes <= 4'd7))
      else $error("closing word byte counts inconsistent");

endmodule

// ===== test/streaming_key_hasher_checker.sv =====
// Checker for the streaming key hasher: predicts each result and compares it.
module streaming_key_hasher_checker #(
   parameter int INDEX_BITS = skh_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [63:0]           req_text_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_key_done,
   input  logic [63:0]           rsp_key_piece,
   input  logic [3:0]            rsp_piece_bytes,
   input  logic [INDEX_BITS-1:0] rsp_bucket_index,
   input  logic [11:0]           rsp_key_length,
   input  logic [63:0]           rsp_rest_word,
   input  logic [2:0]            rsp_rest_bytes,
   output int                    error_count,
   output int                    outstanding
);

   typedef struct packed {
      logic                           key_done;
      logic [63:0]                    key_piece;
      logic [3:0]                     piece_bytes;
      logic [INDEX_BITS-1:0]          bucket_index;
      logic [skh_pkg::COUNT_BITS-1:0] key_length;
      logic [63:0]                    rest_word;
      logic [2:0]                     rest_bytes;
   } key_result_type;

   key_result_type                 pending_results[$];
   logic [skh_pkg::COUNT_BITS-1:0] run_length = '0;
   logic [INDEX_BITS-1:0]          run_index = '0;
   int                             mismatches = 0;

   function automatic logic [INDEX_BITS-1:0] hash_bucket(input logic [63:0] key);
      logic [63:0] k;
      k = key;
      k = (~k) + (k << 21);
      k = k ^ (k >> 24);
      k = (k + (k << 3)) + (k << 8);
      k = k ^ (k >> 14);
      k = (k + (k << 2)) + (k << 4);
      k = k ^ (k >> 28);
      k = k + (k << 31);
      return k[INDEX_BITS-1:0];
   endfunction

   // hash plus count, wrapped to the index width
   function automatic logic [INDEX_BITS-1:0] mix_term(
      input logic [63:0]                    bytes_in,
      input logic [skh_pkg::COUNT_BITS-1:0] count);
      logic [63:0] t;
      t = 64'(hash_bucket(bytes_in)) + 64'(count);
      return t[INDEX_BITS-1:0];
   endfunction

   function automatic logic [skh_pkg::COUNT_BITS-1:0] add_saturated(
      input logic [skh_pkg::COUNT_BITS-1:0] a,
      input logic [3:0]                     b);
      logic [skh_pkg::COUNT_BITS:0] s;
      s = {1'b0, a} + (skh_pkg::COUNT_BITS+1)'(b);
      return (s > skh_pkg::COUNT_MAX) ? skh_pkg::COUNT_MAX : s[skh_pkg::COUNT_BITS-1:0];
   endfunction

   // Updates the running length and index for one word and returns its result.
   function automatic key_result_type scan_and_hash(input logic [63:0] w);
      key_result_type r;
      logic [3:0]     lane;
      logic [7:0]     b;
      logic [63:0]    rest;
      logic [2:0]     rest_n;
      lane = skh_pkg::LANE_NONE;
      for (int i = 0; i < skh_pkg::LANES; i++) begin
         b = w[63-8*i -: 8];
         if (lane == skh_pkg::LANE_NONE && (b == skh_pkg::CH_CR || b == skh_pkg::CH_SP))
            lane = 4'(i);
      end
      r = '0;
      if (lane == skh_pkg::LANE_NONE) begin
         run_length    = add_saturated(run_length, 4'd8);
         run_index     = run_index ^ mix_term(w, run_length);
         r.key_piece    = w;
         r.piece_bytes  = 4'd8;
         r.bucket_index = run_index;
         r.key_length   = run_length;
      end else begin
         r.key_done     = 1'b1;
         r.piece_bytes  = lane;
         r.bucket_index = run_index;
         if (lane != 4'd0) begin
            r.key_piece    = w >> (64 - 8 * lane);
            r.bucket_index = run_index ^ mix_term(r.key_piece, run_length);
         end
         r.key_length = add_saturated(run_length, lane);
         rest   = (lane == skh_pkg::LANE_LAST) ? 64'd0 : (w << (8 * (lane + 1)));
         rest_n = 3'(skh_pkg::LANE_LAST - lane);
         if (rest_n != 3'd0 && rest[63:56] == skh_pkg::CH_LF) begin
            rest   = rest << 8;
            rest_n = rest_n - 3'd1;
         end
         r.rest_word  = rest;
         r.rest_bytes = rest_n;
         run_length   = '0;
         run_index    = '0;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      key_result_type want;
      if (reset) begin
         pending_results.delete();
         run_length = '0;
         run_index  = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual index %h length %h",
                        $time, rsp_bucket_index, rsp_key_length);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("key_done", 64'(want.key_done), 64'(rsp_key_done));
               check_field("key_piece", want.key_piece, rsp_key_piece);
               check_field("piece_bytes", 64'(want.piece_bytes), 64'(rsp_piece_bytes));
               check_field("bucket_index", 64'(want.bucket_index), 64'(rsp_bucket_index));
               check_field("key_length", 64'(want.key_length), 64'(rsp_key_length));
               check_field("rest_word", want.rest_word, rsp_rest_word);
               check_field("rest_bytes", 64'(want.rest_bytes), 64'(rsp_rest_bytes));
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(scan_and_hash(req_text_word));
      end
      error_count <= mismatches;
      outstanding <= pending_results.size();
   end

endmodule

// ===== test/streaming_key_hasher_test.sv =====
// Testbench top: drives text words into the key hasher and reports the verdict.
module streaming_key_hasher_test;

   localparam int INDEX_BITS   = skh_pkg::INDEX_BITS_DEFAULT;
   localparam int IDLE_PERCENT = 24;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 6;     // margin after the last expected result drains
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [63:0]           req_text_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_key_done;
   logic [63:0]           rsp_key_piece;
   logic [3:0]            rsp_piece_bytes;
   logic [INDEX_BITS-1:0] rsp_bucket_index;
   logic [11:0]           rsp_key_length;
   logic [63:0]           rsp_rest_word;
   logic [2:0]            rsp_rest_bytes;

   int error_count;
   int outstanding;
   int quiet_cycles = 0;
   int words_sent = 0;
   bit idling_on = 1'b1;      // cleared for a long stretch in the random part
   bit long_key_done = 1'b0;

   always #4 clock = ~clock;

   streaming_key_hasher #(.INDEX_BITS(INDEX_BITS)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_word    (req_text_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_done     (rsp_key_done),
      .rsp_key_piece    (rsp_key_piece),
      .rsp_piece_bytes  (rsp_piece_bytes),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_key_length   (rsp_key_length),
      .rsp_rest_word    (rsp_rest_word),
      .rsp_rest_bytes   (rsp_rest_bytes)
   );

   streaming_key_hasher_checker #(.INDEX_BITS(INDEX_BITS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_word    (req_text_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_done     (rsp_key_done),
      .rsp_key_piece    (rsp_key_piece),
      .rsp_piece_bytes  (rsp_piece_bytes),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_key_length   (rsp_key_length),
      .rsp_rest_word    (rsp_rest_word),
      .rsp_rest_bytes   (rsp_rest_bytes),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   // Result side backpressure: one fresh decision per cycle, so stalls land
   // on every phase of the pipeline.
   always @(posedge clock) begin
      rsp_ready <= !idling_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Watchdog: any handshake restarts the count; a hung block ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one item and returns right after the edge that accepts it.
   // Must be called just after a rising edge. Valid is lowered only when a
   // gap is taken, so it is never lowered and raised in one step.
   task automatic send_word(input logic [63:0] w);
      int gap = 0;
      while (idling_on && $urandom_range(0, 99) < IDLE_PERCENT)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Any byte value except the two delimiters.
   function automatic logic [7:0] key_byte();
      logic [7:0] b;
      do
         b = 8'($urandom);
      while (b == skh_pkg::CH_CR || b == skh_pkg::CH_SP);
      return b;
   endfunction

   function automatic logic [63:0] whole_word();
      logic [63:0] w;
      for (int i = 0; i < skh_pkg::LANES; i++)
         w[63-8*i -: 8] = key_byte();
      return w;
   endfunction

   // Word ending a key: key bytes, a CR or space in the given lane, then any
   // bytes, with an LF right after the delimiter when asked.
   function automatic logic [63:0] ending_word(input int lane, input bit add_lf);
      logic [63:0] w;
      for (int i = 0; i < skh_pkg::LANES; i++) begin
         if (i < lane)
            w[63-8*i -: 8] = key_byte();
         else if (i == lane)
            w[63-8*i -: 8] = $urandom_range(0, 1) ? skh_pkg::CH_CR : skh_pkg::CH_SP;
         else if (i == lane + 1 && add_lf)
            w[63-8*i -: 8] = skh_pkg::CH_LF;
         else
            w[63-8*i -: 8] = 8'($urandom);
      end
      return w;
   endfunction

   task automatic send_key(input int full_words, input int lane, input bit add_lf);
      repeat (full_words) send_word(whole_word());
      send_word(ending_word(lane, add_lf));
   endtask

   initial begin
      int roll;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      send_word(64'hffff_ffff_ffff_ffff);  // all ones, no delimiter
      send_word(64'h0000_0000_0000_0000);  // all zeros, no delimiter
      send_word(64'h2041_4243_4445_4647);  // space in first lane: empty piece, index kept
      send_word(64'h0d0a_3132_3334_3536);  // CR first, LF skipped
      send_word(64'h0d20_0a41_4243_4445);  // CR first, space follows as plain rest
      send_word(64'h4142_4344_4546_470d);  // CR in last lane: no rest
      send_word(64'h0a0a_0a0a_0a0a_0a0a);  // LF alone is key data
      send_word(64'h6b65_7920_0a0a_7878);  // space in lane 3, only one LF skipped
      send_word(64'h6162_6364_6566_200a);  // space in lane 6, LF eats the only rest byte
      send_word(64'h8081_8283_8485_8620);  // high-bit key bytes, space in last lane
      send_word(64'hfefd_fcfb_fafe_fdfc);
      send_word(64'h7f7e_0d0d_2020_2020);  // first of several delimiters wins
      send_word(64'h3131_3131_0d0a_0a31);  // CR in lane 4 with LF
      send_word(64'h5566_7788_99aa_bbcc);
      send_word(64'h1122_3344_5520_ffee);  // space in lane 5, no LF
      send_word(64'h20ff_ffff_ffff_ffff);  // space in first lane straight after a closing word: empty key

      // --- random part: mostly well formed keys, some raw noise words ---
      words_sent = 0;
      while (words_sent < RANDOM_ITEMS) begin
         idling_on = !(words_sent >= 700 && words_sent < 900);
         if (!long_key_done && words_sent >= 300) begin
            // one long key drives the length through saturation
            send_key($urandom_range(512, 516), $urandom_range(0, 7), $urandom_range(0, 1));
            long_key_done = 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
               send_word({$urandom, $urandom});
            else
               send_key($urandom_range(0, 6), $urandom_range(0, 7), $urandom_range(0, 1));
         end
      end
      idling_on = 1'b1;
      req_valid <= 1'b0;

      // drain: wait for every expected result, then a few more cycles
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
